@@ hdl/sarm_pkg.sv @@
// ----------------------------------------------------------------------------
// sarm_pkg
// Shared types and constants of the suffix array read mapper.
// ----------------------------------------------------------------------------
package sarm_pkg;

  localparam int GENOME_MAX = 8192;
  localparam int GADDR_W    = $clog2(GENOME_MAX);
  localparam int GLEN_W     = GADDR_W + 1;
  localparam int SEED_LEN   = 25;
  localparam int READ_MAX   = 128;
  localparam int RADDR_W    = $clog2(READ_MAX);
  localparam int RLEN_W     = RADDR_W + 1;
  localparam int SYM_W      = 3;
  localparam int MM_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [1:0] {
    CMD_GENOME = 2'd0,
    CMD_SUFFIX = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_MM = 2'd0,
    REG_GLEN   = 2'd1,
    REG_SPARE2 = 2'd2,
    REG_SPARE3 = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MID, ST_OFF, ST_CISS, ST_CCMP,
    ST_TADR, ST_TOFF, ST_TISS, ST_TCMP, ST_DONE
  } sarm_state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [GADDR_W-1:0] index;
    logic [SYM_W-1:0]   base;
    logic [GADDR_W-1:0] suffix_value;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic               mapped;
    logic [GADDR_W-1:0] position;
    logic               strand;
  } out_word_t;

  typedef struct packed {
    logic               done;
    logic               mapped;
    logic [GADDR_W-1:0] position;
    logic               strand;
  } eng_res_t;

  function automatic logic [SYM_W-1:0] complement(input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] r;
    r = b;
    if (b >= 3'd1 && b <= 3'd4) r = 3'd5 - b;
    return r;
  endfunction

endpackage

@@ hdl/suffix_array_read_mapper.sv @@
// ----------------------------------------------------------------------------
// suffix_array_read_mapper
// Genome and suffix array store with a read mapper: seed search over the
// suffix array for both strands, then a tail mismatch count.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Word
// in_      in   in_valid/in_stall    in_word_t (command,index,base,...)
// out_     out  out_valid/out_stall  out_word_t (mapped,position,strand)
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Load words and non-last read bases are taken only while the mapper is idle.
// A last read base starts the mapper; it holds in_stall while it runs two
// binary searches per strand over the seed and then counts tail mismatches;
// one shared symbol comparator and the single-ported stores pace this work.
// Reset clears control only; the stores are undefined until loaded.
// A finished result moves straight into the output register; only while
// that register still holds an unaccepted word does the mapper wait in its
// done state, and in_stall stays high until it can hand over.
// ----------------------------------------------------------------------------
module suffix_array_read_mapper (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sarm_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sarm_pkg::out_word_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sarm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sarm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sarm_pkg::*;

  logic [MM_W-1:0]    max_mm_r;
  logic [GLEN_W-1:0]  glen_r;
  logic [GLEN_W-1:0]  n_act;
  logic [RLEN_W-1:0]  rlen_r, rlen_nxt;
  logic               out_valid_r;
  out_word_t          out_word_r;

  logic               in_acc, cfg_acc, busy, start, ack;
  logic [RLEN_W-1:0]  len_new;
  eng_res_t           res;

  logic [GADDR_W-1:0] sa_addr_e, gn_addr_e, sa_addr, gn_addr, sa_q;
  logic [RADDR_W-1:0] rb_addr_e, rb_addr;
  logic [SYM_W-1:0]   gn_q, rb_q;
  logic               we_g, we_s, we_r;

  assign in_stall  = busy;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // genome_length above the store depth acts as the full depth
  assign n_act = (glen_r > GLEN_W'(GENOME_MAX)) ? GLEN_W'(GENOME_MAX) : glen_r;

  assign we_g = in_acc && (in_data.command == CMD_GENOME);
  assign we_s = in_acc && (in_data.command == CMD_SUFFIX);
  assign we_r = in_acc && (in_data.command == CMD_READ) && (rlen_r < RLEN_W'(READ_MAX));

  // bases past the buffer depth are dropped, length saturates
  assign len_new = we_r ? rlen_r + RLEN_W'(1) : rlen_r;
  assign start   = in_acc && (in_data.command == CMD_READ) && in_data.last;

  always_comb begin
    rlen_nxt = rlen_r;
    if (in_acc && (in_data.command == CMD_READ)) begin
      rlen_nxt = in_data.last ? '0 : len_new;
    end
  end

  // stores are written while idle and read by the mapper while busy
  assign sa_addr = busy ? sa_addr_e : in_data.index;
  assign gn_addr = busy ? gn_addr_e : in_data.index;
  assign rb_addr = busy ? rb_addr_e : rlen_r[RADDR_W-1:0];

  assign ack = res.done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mm_r    <= MM_W'(3);
      glen_r      <= GLEN_W'(GENOME_MAX);
      rlen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rlen_r <= rlen_nxt;
      if (cfg_acc) begin
        case (reg_idx_t'(cfg_index))
          REG_MAX_MM: max_mm_r <= cfg_data[MM_W-1:0];
          REG_GLEN:   glen_r   <= cfg_data[GLEN_W-1:0];
          default: ;
        endcase
      end
      if (ack)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (ack) begin
      out_word_r.mapped   <= res.mapped;
      out_word_r.position <= res.position;
      out_word_r.strand   <= res.strand;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  sarm_ram #(.WIDTH(SYM_W), .DEPTH(GENOME_MAX)) u_genome (
    .clk(clk), .we(we_g), .addr(gn_addr), .wdata(in_data.base), .rdata(gn_q)
  );

  sarm_ram #(.WIDTH(GADDR_W), .DEPTH(GENOME_MAX)) u_suffix (
    .clk(clk), .we(we_s), .addr(sa_addr), .wdata(in_data.suffix_value), .rdata(sa_q)
  );

  sarm_ram #(.WIDTH(SYM_W), .DEPTH(READ_MAX)) u_read (
    .clk(clk), .we(we_r), .addr(rb_addr), .wdata(in_data.base), .rdata(rb_q)
  );

  sarm_engine u_engine (
    .clk(clk), .rst_n(rst_n), .start(start), .len(len_new), .n(n_act),
    .max_mm(max_mm_r), .ack(ack), .sa_q(sa_q), .gn_q(gn_q), .rb_q(rb_q),
    .sa_addr(sa_addr_e), .gn_addr(gn_addr_e), .rb_addr(rb_addr_e),
    .busy(busy), .res(res)
  );

  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.mapped) |-> (out_data.position == '0 && !out_data.strand))
    else $error("unmapped word carries position or strand");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("mapper not busy after last read base");

  a_rlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rlen_r <= RLEN_W'(READ_MAX))
    else $error("read length beyond buffer depth");

endmodule

@@ hdl/sarm_ram.sv @@
// ----------------------------------------------------------------------------
// sarm_ram
// Single-port RAM, one address per cycle for a write and a read (old word), registered read data.
// ----------------------------------------------------------------------------
module sarm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

@@ hdl/sarm_engine.sv @@
// ----------------------------------------------------------------------------
// sarm_engine
// Mapping sequencer: binary searches, seed compare and tail check per strand,
// all through one symbol comparator.
// ----------------------------------------------------------------------------
module sarm_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sarm_pkg::RLEN_W-1:0] len,
  input  logic [sarm_pkg::GLEN_W-1:0] n,
  input  logic [sarm_pkg::MM_W-1:0]   max_mm,
  input  logic                        ack,
  input  logic [sarm_pkg::GADDR_W-1:0] sa_q,
  input  logic [sarm_pkg::SYM_W-1:0]  gn_q,
  input  logic [sarm_pkg::SYM_W-1:0]  rb_q,
  output logic [sarm_pkg::GADDR_W-1:0] sa_addr,
  output logic [sarm_pkg::GADDR_W-1:0] gn_addr,
  output logic [sarm_pkg::RADDR_W-1:0] rb_addr,
  output logic                        busy,
  output sarm_pkg::eng_res_t          res
);
  import sarm_pkg::*;

  sarm_state_t        state_r, state_nxt;
  logic               strand_r, strand_nxt;
  logic               pass_r, pass_nxt;
  logic [GLEN_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, lb_r, lb_nxt;
  logic [GADDR_W-1:0] off_r, off_nxt;
  logic [RLEN_W-1:0]  k_r, k_nxt, len_r, len_nxt;
  logic [MM_W-1:0]    mism_r, mism_nxt;
  logic               hit_f_r, hit_f_nxt, hit_r_r, hit_r_nxt;
  logic [GADDR_W-1:0] pos_f_r, pos_f_nxt, pos_r_r, pos_r_nxt;

  logic [RLEN_W-1:0]  seed_len;
  logic [GLEN_W-1:0]  g;
  logic [RLEN_W-1:0]  rev_idx;
  logic [SYM_W-1:0]   sym;
  logic               sym_lt, sym_gt;
  logic               dec, dec_lt, dec_eq;
  logic               go_right;
  logic               fin_strand, strand_hit;

  assign seed_len = (len_r < RLEN_W'(SEED_LEN)) ? len_r : RLEN_W'(SEED_LEN);
  assign g        = {1'b0, off_r} + GLEN_W'(k_r);
  assign rev_idx  = len_r - RLEN_W'(1) - k_r;
  assign sym      = strand_r ? complement(rb_q) : rb_q;
  // shared comparator
  assign sym_lt   = gn_q < sym;
  assign sym_gt   = gn_q > sym;
  assign go_right = dec_lt || (pass_r && dec_eq);

  assign sa_addr = (state_r == ST_TADR) ? lb_r[GADDR_W-1:0] : mid_nxt[GADDR_W-1:0];
  assign gn_addr = g[GADDR_W-1:0];
  assign rb_addr = strand_r ? rev_idx[RADDR_W-1:0] : k_r[RADDR_W-1:0];
  assign busy    = (state_r != ST_IDLE);

  assign res.done     = (state_r == ST_DONE);
  assign res.mapped   = hit_f_r ^ hit_r_r;
  assign res.position = (hit_f_r ^ hit_r_r) ? (hit_f_r ? pos_f_r : pos_r_r) : '0;
  assign res.strand   = (hit_f_r ^ hit_r_r) & hit_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    strand_r <= strand_nxt;
    pass_r   <= pass_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    lb_r     <= lb_nxt;
    off_r    <= off_nxt;
    k_r      <= k_nxt;
    len_r    <= len_nxt;
    mism_r   <= mism_nxt;
    hit_f_r  <= hit_f_nxt;
    hit_r_r  <= hit_r_nxt;
    pos_f_r  <= pos_f_nxt;
    pos_r_r  <= pos_r_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    strand_nxt = strand_r;
    pass_nxt   = pass_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    lb_nxt     = lb_r;
    off_nxt    = off_r;
    k_nxt      = k_r;
    len_nxt    = len_r;
    mism_nxt   = mism_r;
    hit_f_nxt  = hit_f_r;
    hit_r_nxt  = hit_r_r;
    pos_f_nxt  = pos_f_r;
    pos_r_nxt  = pos_r_r;
    dec        = 1'b0;
    dec_lt     = 1'b0;
    dec_eq     = 1'b0;
    fin_strand = 1'b0;
    strand_hit = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          len_nxt    = len;
          strand_nxt = 1'b0;
          pass_nxt   = 1'b0;
          lo_nxt     = '0;
          hi_nxt     = n;
          hit_f_nxt  = 1'b0;
          hit_r_nxt  = 1'b0;
          state_nxt  = ST_MID;
        end
      end
      ST_MID: begin
        if (lo_r < hi_r) begin
          mid_nxt   = lo_r + ((hi_r - lo_r) >> 1);
          state_nxt = ST_OFF;
        end else if (!pass_r) begin
          lb_nxt   = lo_r;
          pass_nxt = 1'b1;
          lo_nxt   = '0;
          hi_nxt   = n;
        end else if (lb_r >= n || lo_r != lb_r + GLEN_W'(1)) begin
          fin_strand = 1'b1;
        end else begin
          state_nxt = ST_TADR;
        end
      end
      ST_OFF: begin
        off_nxt   = sa_q;
        k_nxt     = '0;
        state_nxt = ST_CISS;
      end
      ST_CISS: begin
        if (k_r >= seed_len) begin
          dec = 1'b1; dec_eq = 1'b1;
        end else if (g >= n) begin
          dec = 1'b1; dec_lt = 1'b1;
        end else begin
          state_nxt = ST_CCMP;
        end
      end
      ST_CCMP: begin
        if (sym_lt) begin
          dec = 1'b1; dec_lt = 1'b1;
        end else if (sym_gt) begin
          dec = 1'b1;
        end else begin
          k_nxt     = k_r + RLEN_W'(1);
          state_nxt = ST_CISS;
        end
      end
      ST_TADR: begin
        state_nxt = ST_TOFF;
      end
      ST_TOFF: begin
        off_nxt   = sa_q;
        k_nxt     = RLEN_W'(SEED_LEN);
        mism_nxt  = '0;
        state_nxt = ST_TISS;
      end
      ST_TISS: begin
        if (k_r >= len_r) begin
          fin_strand = 1'b1;
          strand_hit = (mism_r <= max_mm);
        end else if (g >= n) begin
          mism_nxt = mism_r + MM_W'(1);
          k_nxt    = k_r + RLEN_W'(1);
        end else begin
          state_nxt = ST_TCMP;
        end
      end
      ST_TCMP: begin
        if (sym_lt || sym_gt) mism_nxt = mism_r + MM_W'(1);
        k_nxt     = k_r + RLEN_W'(1);
        state_nxt = ST_TISS;
      end
      ST_DONE: begin
        if (ack) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (dec) begin
      if (go_right) lo_nxt = mid_r + GLEN_W'(1);
      else          hi_nxt = mid_r;
      state_nxt = ST_MID;
    end

    if (fin_strand) begin
      if (!strand_r) begin
        hit_f_nxt  = strand_hit;
        pos_f_nxt  = off_r;
        strand_nxt = 1'b1;
        pass_nxt   = 1'b0;
        lo_nxt     = '0;
        hi_nxt     = n;
        state_nxt  = ST_MID;
      end else begin
        hit_r_nxt = strand_hit;
        pos_r_nxt = off_r;
        state_nxt = ST_DONE;
      end
    end
  end

endmodule

@@ dv/sarm_checker.sv @@
// ----------------------------------------------------------------------------
// sarm_checker
// Watches the input, result and register channels of the read mapper, keeps
// its own copy of the stores and registers, predicts each mapping result and
// compares it with the word the block hands out.
// ----------------------------------------------------------------------------
module sarm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  sarm_pkg::in_word_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  sarm_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sarm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sarm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              results,
  output int                              mapped_cnt
);
  import sarm_pkg::*;

  logic [SYM_W-1:0]   genome_mem [GENOME_MAX];
  logic [GADDR_W-1:0] sa_mem     [GENOME_MAX];
  logic [SYM_W-1:0]   rd_buf     [READ_MAX];
  logic [SYM_W-1:0]   strand_seq [READ_MAX];
  int                 rd_len;
  int                 mm_limit;
  int                 glen;
  out_word_t          expected_maps [$];

  function automatic logic [SYM_W-1:0] pair_of(logic [SYM_W-1:0] b);
    case (b)
      3'd1:    return 3'd4;
      3'd2:    return 3'd3;
      3'd3:    return 3'd2;
      3'd4:    return 3'd1;
      default: return b;
    endcase
  endfunction

  // -1 suffix below seed, 0 equal, 1 above
  function automatic int seed_order(int off, int slen, int n);
    for (int k = 0; k < slen; k++) begin
      if (off + k >= n) return -1;
      if (genome_mem[off+k] < strand_seq[k]) return -1;
      if (genome_mem[off+k] > strand_seq[k]) return 1;
    end
    return 0;
  endfunction

  function automatic bit map_one(int len, output int pos);
    int n, slen, lo, hi, mid, lb, ub, off, mism;
    n    = (glen > GENOME_MAX) ? GENOME_MAX : glen;
    slen = (len < SEED_LEN) ? len : SEED_LEN;
    pos  = 0;
    lo = 0; hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (seed_order(sa_mem[mid], slen, n) < 0) lo = mid + 1;
      else hi = mid;
    end
    lb = lo;
    lo = 0; hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (seed_order(sa_mem[mid], slen, n) <= 0) lo = mid + 1;
      else hi = mid;
    end
    ub = lo;
    if (lb >= n || ub != lb + 1) return 0;
    off  = sa_mem[lb];
    mism = 0;
    for (int i = SEED_LEN; i < len; i++)
      if (off + i >= n || genome_mem[off+i] != strand_seq[i]) mism++;
    if (mism > mm_limit) return 0;
    pos = off;
    return 1;
  endfunction

  function automatic out_word_t map_read();
    out_word_t r;
    int        len, pf, pr;
    bit        hf, hr;
    len    = rd_len;
    rd_len = 0;
    for (int i = 0; i < len; i++) strand_seq[i] = rd_buf[i];
    hf = map_one(len, pf);
    for (int i = 0; i < len; i++) strand_seq[i] = pair_of(rd_buf[len-1-i]);
    hr = map_one(len, pr);
    r = '0;
    if (hf != hr) begin
      r.mapped   = 1'b1;
      r.position = hf ? pf[GADDR_W-1:0] : pr[GADDR_W-1:0];
      r.strand   = !hf;
    end
    return r;
  endfunction

  assign pending = expected_maps.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      rd_len     = 0;
      mm_limit   = 3;
      glen       = GENOME_MAX;
      errors     = 0;
      results    = 0;
      mapped_cnt = 0;
      expected_maps.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_MM) mm_limit = cfg_data[MM_W-1:0];
        else if (cfg_index == REG_GLEN) glen = cfg_data;
      end
      if (in_valid && !in_stall) begin
        case (in_data.command)
          CMD_GENOME: genome_mem[in_data.index] = in_data.base;
          CMD_SUFFIX: sa_mem[in_data.index] = in_data.suffix_value;
          CMD_READ: begin
            if (rd_len < READ_MAX) begin
              rd_buf[rd_len] = in_data.base;
              rd_len++;
            end
            if (in_data.last) expected_maps.push_back(map_read());
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results++;
        if (out_data.mapped) mapped_cnt++;
        if (expected_maps.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: mapped %0d pos %0d strand %0d",
                     out_data.mapped, out_data.position, out_data.strand);
        end else begin
          exp_w = expected_maps.pop_front();
          if (exp_w.mapped !== out_data.mapped || exp_w.position !== out_data.position
              || exp_w.strand !== out_data.strand) begin
            errors++;
            if (errors <= 10)
              $display("result %0d mismatch: exp mapped %0d pos %0d strand %0d, got %0d %0d %0d",
                       results, exp_w.mapped, exp_w.position, exp_w.strand,
                       out_data.mapped, out_data.position, out_data.strand);
          end
        end
      end
    end
  end

endmodule

@@ dv/suffix_array_read_mapper_test.sv @@
// ----------------------------------------------------------------------------
// suffix_array_read_mapper_test
// Loads genomes and suffix arrays, streams reads of both strands with tail
// mismatches, noise and overflow, across several register settings; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module suffix_array_read_mapper_test;
  import sarm_pkg::*;

  localparam int CYCLE_LIMIT = 30_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors, pending, results, mapped_cnt;
  int cycles = 0;
  int words_sent;
  bit quiet;      // no idling at all on either side
  bit calm;       // sender gaps off for this phase

  // genome image and suffix array as loaded, plus a read under construction
  logic [SYM_W-1:0] gen [GENOME_MAX];
  int               sa  [GENOME_MAX];
  logic [SYM_W-1:0] rb  [160];

  suffix_array_read_mapper dut (.*);

  sarm_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall: random bursts at random times, none once quiet
  initial begin
    int left;
    left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        left = 0;
        out_stall <= 1'b0;
      end else if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        left = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_word_t mk_word(cmd_t c, int idx, int b, int sv, bit lst);
    in_word_t w;
    w.command      = c;
    w.index        = idx[GADDR_W-1:0];
    w.base         = b[SYM_W-1:0];
    w.suffix_value = sv[GADDR_W-1:0];
    w.last         = lst;
    return w;
  endfunction

  // one word across the input channel; valid stays up between back-to-back words
  task automatic send_word(in_word_t w);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, int v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit suffix_lt(int a, int b, int n);
    for (int k = 0; ; k++) begin
      if (a + k >= n) return 1;
      if (b + k >= n) return 0;
      if (gen[a+k] != gen[b+k]) return gen[a+k] < gen[b+k];
    end
  endfunction

  // genome of n symbols ending in '$'; sorted suffix array or random entries
  task automatic load_genome(int n, bit sorted);
    int t, j;
    for (int i = 0; i < n - 1; i++)
      gen[i] = ($urandom_range(0, 40) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
    gen[n-1] = 3'd0;
    for (int i = 0; i < n; i++) sa[i] = sorted ? i : $urandom_range(0, GENOME_MAX - 1);
    if (sorted) begin
      for (int i = 1; i < n; i++) begin
        t = sa[i];
        j = i - 1;
        while (j >= 0 && suffix_lt(t, sa[j], n)) begin
          sa[j+1] = sa[j];
          j--;
        end
        sa[j+1] = t;
      end
    end
    for (int i = 0; i < n; i++)
      send_word(mk_word(CMD_GENOME, i, gen[i], $urandom, 1'($urandom)));
    for (int i = 0; i < n; i++)
      send_word(mk_word(CMD_SUFFIX, i, $urandom, sa[i], 1'($urandom)));
  endtask

  task automatic send_read(int len);
    for (int i = 0; i < len; i++)
      send_word(mk_word(CMD_READ, $urandom, rb[i], $urandom, i == len - 1));
  endtask

  // read copied from the genome at a random start, with tail edits and strand
  task automatic genome_read(int n, int len, int edits, bit rev);
    int p;
    logic [SYM_W-1:0] tmp [160];
    p = $urandom_range(0, n - 1);
    for (int i = 0; i < len; i++)
      rb[i] = (p + i < n) ? gen[p+i] : 3'($urandom_range(1, 4));
    for (int e = 0; e < edits && len > SEED_LEN; e++)
      rb[$urandom_range(SEED_LEN, len - 1)] = $urandom_range(1, 4);
    if (rev) begin
      for (int i = 0; i < len; i++) tmp[i] = rb[len-1-i];
      for (int i = 0; i < len; i++)
        rb[i] = (tmp[i] >= 1 && tmp[i] <= 4) ? 3'(5 - tmp[i]) : tmp[i];
    end
    send_read(len);
  endtask

  task automatic noise_read(int len);
    for (int i = 0; i < len; i++) rb[i] = $urandom_range(0, 7);
    send_read(len);
  endtask

  initial begin
    int n, mm;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    words_sent = 0;
    quiet     = 1'b0;
    calm      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-symbol genome, both strands see the lone terminator
    write_reg(REG_GLEN, 1);
    write_reg(REG_MAX_MM, 0);
    load_genome(1, 1'b1);
    rb[0] = 3'd0;
    send_read(1);
    wait_idle();
    // empty genome: nothing can hit
    write_reg(REG_GLEN, 0);
    rb[0] = 3'd1;
    send_read(1);
    wait_idle();
    // spare registers take writes without effect; 300 wraps in the 8-bit limit
    write_reg(REG_SPARE2, 14'h3fff);
    write_reg(REG_SPARE3, 5);
    write_reg(REG_MAX_MM, 300);
    write_reg(REG_GLEN, 48);
    load_genome(48, 1'b1);
    genome_read(48, 30, 0, 1'b0);           // forward exact
    genome_read(48, 30, 0, 1'b1);           // reverse complement
    genome_read(48, 5, 0, 1'b0);            // seed shorter than SEED_LEN
    genome_read(48, 25, 0, 1'b1);           // seed only, empty tail
    genome_read(48, 140, 3, 1'b0);          // overflow past READ_MAX
    send_word(mk_word(CMD_NONE, $urandom, $urandom, $urandom, 1'b1));
    noise_read(3);                          // random symbols, some above T
    wait_idle();
    write_reg(REG_MAX_MM, 0);
    genome_read(48, 40, 1, 1'b0);           // one tail edit, no mismatch allowed
    genome_read(48, 40, 0, 1'b0);
    wait_idle();
    write_reg(REG_MAX_MM, 128);
    genome_read(48, 128, 8, 1'b1);
    wait_idle();

    // random phases: small genomes, mostly well-formed reads
    while (words_sent < 640) begin
      calm = ($urandom_range(0, 3) == 0);
      n    = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : $urandom_range(20, 120);
      case ($urandom_range(0, 5))
        0: mm = 0;
        1: mm = 1;
        2: mm = 128;
        3: mm = 255;
        default: mm = $urandom_range(0, 6);
      endcase
      write_reg(REG_MAX_MM, mm);
      write_reg(REG_GLEN, n);
      load_genome(n, $urandom_range(0, 7) != 0);
      repeat (8) begin
        case ($urandom_range(0, 9))
          0: noise_read($urandom_range(1, 30));
          1: send_word(mk_word(CMD_NONE, $urandom, $urandom, $urandom, 1'($urandom)));
          2: begin
            // stray genome rewrite inside the loaded range
            send_word(mk_word(CMD_GENOME, $urandom_range(0, n - 1),
                              $urandom_range(0, 4), $urandom, 1'b0));
          end
          3: genome_read(n, $urandom_range(1, 24), 0, 1'($urandom));
          default: genome_read(n, $urandom_range(25, 45), $urandom_range(0, 4), 1'($urandom));
        endcase
      end
      wait_idle();
    end

    // closing stretch without any idling
    quiet = 1'b1;
    write_reg(REG_GLEN, 64);
    write_reg(REG_MAX_MM, 2);
    load_genome(64, 1'b1);
    repeat (6) genome_read(64, $urandom_range(20, 40), $urandom_range(0, 3), 1'($urandom));
    wait_idle();
    repeat (50) @(posedge clk);

    $display("%0d input words, %0d reads mapped, %0d of them hit a unique position",
             words_sent, results, mapped_cnt);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
